/* hw/rtl/spq_pkg.sv */
// spq_pkg: shared sizes, codes and types of the stable priority queue.
// No dependencies; every other file in hw/rtl but spq_ram imports it.
package spq_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 8;
	localparam int PRIO_LEVELS = 4;
	localparam int PRI_W       = 3;
	localparam int LVL_W       = $clog2(PRIO_LEVELS);
	localparam int PTR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int ADDR_W      = LVL_W + PTR_W;
	localparam int MEM_DEPTH   = PRIO_LEVELS * (1 << PTR_W);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [LVL_W-1:0]  lvl_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// Command from the sequencer to the bookkeeping block.
	typedef struct packed {
		logic push;
		logic pop;
		lvl_t level;
	} book_cmd_t;

	// Status from the bookkeeping block to the sequencer.
	typedef struct packed {
		cnt_t  total;
		logic  full;
		logic  empty;
		lvl_t  top_level;
		addr_t wr_addr;
		addr_t rd_addr;
	} book_stat_t;

	// Saturate a requested priority to 1..4 and map it to a level index 0..3.
	function automatic lvl_t pri_to_level(input logic [PRI_W-1:0] pri);
		lvl_t lvl;
		case (pri)
			3'd0, 3'd1: lvl = LVL_W'(0);
			3'd2:       lvl = LVL_W'(1);
			3'd3:       lvl = LVL_W'(2);
			default:    lvl = LVL_W'(PRIO_LEVELS - 1);
		endcase
		return lvl;
	endfunction

endpackage

/* hw/rtl/spq_ram.sv */
// spq_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module spq_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 6,
	parameter int DEPTH  = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/spq_book.sv */
// spq_book: per-priority ring pointers and counts, head selection.
// Depends on spq_pkg.
module spq_book (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::book_cmd_t cmd,
	output spq_pkg::book_stat_t stat
);
	import spq_pkg::*;

	ptr_t head_q    [PRIO_LEVELS];
	ptr_t tail_q    [PRIO_LEVELS];
	cnt_t lvl_cnt_q [PRIO_LEVELS];
	cnt_t total_q;
	lvl_t top_lvl;
	logic any_valid;

	// Find the highest level that holds an entry
	always_comb begin
		top_lvl   = '0;
		any_valid = 1'b0;
		for (int i = 0; i < PRIO_LEVELS; i++) begin
			if (lvl_cnt_q[i] != '0) begin
				top_lvl   = LVL_W'(i);
				any_valid = 1'b1;
			end
		end
	end

	always_comb begin
		stat.total     = total_q;
		stat.full      = (total_q == CNT_W'(CAPACITY));
		stat.empty     = !any_valid;
		stat.top_level = top_lvl;
		stat.wr_addr   = {cmd.level, tail_q[cmd.level]};
		stat.rd_addr   = {top_lvl, head_q[top_lvl]};
	end

	// Advance tail on push, head on pop; hold otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				head_q[i]    <= '0;
				tail_q[i]    <= '0;
				lvl_cnt_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q[cmd.level] <= (tail_q[cmd.level] == PTR_W'(CAPACITY - 1)) ? '0 :
					PTR_W'(tail_q[cmd.level] + 1'b1);
				lvl_cnt_q[cmd.level] <= CNT_W'(lvl_cnt_q[cmd.level] + 1'b1);
				total_q <= CNT_W'(total_q + 1'b1);
			end else if (cmd.pop) begin
				head_q[top_lvl] <= (head_q[top_lvl] == PTR_W'(CAPACITY - 1)) ? '0 :
					PTR_W'(head_q[top_lvl] + 1'b1);
				lvl_cnt_q[top_lvl] <= CNT_W'(lvl_cnt_q[top_lvl] - 1'b1);
				total_q <= CNT_W'(total_q - 1'b1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push issued on a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop issued on an empty queue");
	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 2)'(total_q) == (CNT_W + 2)'(lvl_cnt_q[0]) + (CNT_W + 2)'(lvl_cnt_q[1])
			+ (CNT_W + 2)'(lvl_cnt_q[2]) + (CNT_W + 2)'(lvl_cnt_q[3]))
		else $error("total count disagrees with level counts");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> total_q == CNT_W'($past(total_q) + 1'b1))
		else $error("push did not advance total count");
`endif

endmodule

/* hw/rtl/stable_priority_queue_core.sv */
// stable_priority_queue_core: stable priority queue, one ring per priority in one RAM.
// A push loads its result in ST_EXEC; a pop of a non-empty queue does so in ST_READ (registered RAM read).
// One item in flight: busy is high while the item is in ST_EXEC or ST_READ and low again
// in the result cycle. The receiver cannot stall; res_strobe pulses once per item.
// Reset (arst_n low) empties the queue at once; the RAM contents are not cleared.
// Depends on spq_pkg, spq_ram, spq_book.
module stable_priority_queue_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [spq_pkg::VALUE_WIDTH-1:0]   value,
	input  logic [spq_pkg::PRI_W-1:0]         priority_req,
	output logic                              res_strobe,
	output logic [spq_pkg::VALUE_WIDTH-1:0]   popped_value,
	output logic [spq_pkg::PRI_W-1:0]         popped_priority,
	output logic                              done_res,
	output logic [spq_pkg::CNT_W-1:0]         count_after
);
	import spq_pkg::*;

	state_t state_q, state_d;
	logic                   op_q;
	logic [VALUE_WIDTH-1:0] val_q;
	lvl_t                   lvl_q;
	lvl_t                   pop_lvl_q;

	logic                   strobe_q;
	logic [VALUE_WIDTH-1:0] pv_q;
	logic [PRI_W-1:0]       pp_q;
	logic                   done_q;
	cnt_t                   cnt_q;

	book_cmd_t  cmd;
	book_stat_t stat;
	logic       mem_we, mem_re;
	logic [VALUE_WIDTH-1:0] rd_data;

	// Result load controls
	logic                   res_load;
	logic [VALUE_WIDTH-1:0] res_pv;
	logic [PRI_W-1:0]       res_pp;
	logic                   res_done;
	cnt_t                   res_cnt;
	logic                   capture;

	spq_book u_book (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	spq_ram #(
		.DATA_W (VALUE_WIDTH),
		.ADDR_W (ADDR_W),
		.DEPTH  (MEM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (stat.wr_addr),
		.wr_data (val_q),
		.re      (mem_re),
		.rd_addr (stat.rd_addr),
		.rd_data (rd_data)
	);

	// Next state, bookkeeping commands and result values
	always_comb begin
		state_d   = state_q;
		capture   = 1'b0;
		cmd.push  = 1'b0;
		cmd.pop   = 1'b0;
		cmd.level = lvl_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_load  = 1'b0;
		res_pv    = '0;
		res_pp    = '0;
		res_done  = 1'b0;
		res_cnt   = stat.total;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_PUSH) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					if (!stat.full) begin
						cmd.push = 1'b1;
						mem_we   = 1'b1;
						res_done = 1'b1;
						res_cnt  = CNT_W'(stat.total + 1'b1);
					end
				end else if (stat.empty) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cmd.pop = 1'b1;
					mem_re  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_pv   = rd_data;
				res_pp   = PRI_W'({1'b0, pop_lvl_q}) + PRI_W'(1);
				res_done = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted transfer and the level being popped
	always_ff @(posedge clk) begin
		if (capture) begin
			op_q  <= operation;
			val_q <= value;
			lvl_q <= pri_to_level(priority_req);
		end
		if (cmd.pop) begin
			pop_lvl_q <= stat.top_level;
		end
	end

	// Result strobe: high for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_load;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			pv_q   <= res_pv;
			pp_q   <= res_pp;
			done_q <= res_done;
			cnt_q  <= res_cnt;
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign res_strobe      = strobe_q;
	assign popped_value    = pv_q;
	assign popped_priority = pp_q;
	assign done_res        = done_q;
	assign count_after     = cnt_q;

`ifndef SYNTHESIS
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_READ))
		else $error("result strobe without an executing item");
	a_read_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(cmd.pop))
		else $error("read state entered without a pop");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("RAM written and read in one cycle");
`endif

endmodule

/* tb/tb_stable_priority_queue_core.sv */
`timescale 1ns / 1ps
// tb_stable_priority_queue_core: self-checking bench for the stable priority queue core.
// Depends on spq_pkg and the stable_priority_queue_core RTL; keeps its own sorted queue copy.
module tb_stable_priority_queue_core;
	import spq_pkg::*;

	typedef struct {
		logic [VALUE_WIDTH-1:0] pop_val;
		logic [PRI_W-1:0]       pop_pri;
		logic                   stored;
		logic [CNT_W-1:0]       count;
	} reply_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   operation;
	logic [VALUE_WIDTH-1:0] value;
	logic [PRI_W-1:0]       priority_req;
	logic                   res_strobe;
	logic [VALUE_WIDTH-1:0] popped_value;
	logic [PRI_W-1:0]       popped_priority;
	logic                   done_res;
	logic [CNT_W-1:0]       count_after;

	// Sorted copy of the queue contents, head at index 0
	logic [VALUE_WIDTH-1:0] held_value [CAPACITY];
	logic [PRI_W-1:0]       held_prio [CAPACITY];
	int                     held_count;

	reply_t replies_due[$];
	int     fault_count;

	stable_priority_queue_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.value          (value),
		.priority_req   (priority_req),
		.res_strobe     (res_strobe),
		.popped_value   (popped_value),
		.popped_priority(popped_priority),
		.done_res       (done_res),
		.count_after    (count_after)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
	endtask

	// Apply one operation to the sorted copy and queue the reply it must produce
	task automatic queue_step(input logic op, input logic [VALUE_WIDTH-1:0] val,
			input logic [PRI_W-1:0] pri);
		reply_t r;
		logic [PRI_W-1:0] lvl;
		int pos;
		r.pop_val = '0;
		r.pop_pri = '0;
		r.stored  = 1'b0;
		// saturate priority into 1..PRIO_LEVELS
		if (pri == 0) begin
			lvl = PRI_W'(1);
		end else if (pri > PRIO_LEVELS) begin
			lvl = PRI_W'(PRIO_LEVELS);
		end else begin
			lvl = pri;
		end
		if (op == OP_PUSH) begin
			if (held_count < CAPACITY) begin
				// insert behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_count && held_prio[pos] >= lvl) pos++;
				for (int i = held_count; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i]  = held_prio[i-1];
				end
				held_value[pos] = val;
				held_prio[pos]  = lvl;
				held_count++;
				r.stored = 1'b1;
			end
		end else begin
			if (held_count > 0) begin
				r.pop_val = held_value[0];
				r.pop_pri = held_prio[0];
				for (int i = 1; i < held_count; i++) begin
					held_value[i-1] = held_value[i];
					held_prio[i-1]  = held_prio[i];
				end
				held_count--;
				r.stored = 1'b1;
			end
		end
		r.count = CNT_W'(held_count);
		replies_due.push_back(r);
	endtask

	// Present one command and hold it until the transfer; start stays high on return
	task automatic send_op(input logic op, input logic [VALUE_WIDTH-1:0] val,
			input logic [PRI_W-1:0] pri);
		start        <= 1'b1;
		operation    <= op;
		value        <= val;
		priority_req <= pri;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		queue_step(op, val, pri);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Check each result against the oldest outstanding reply
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n === 1'b1 && res_strobe === 1'b1) begin
			if (replies_due.size() == 0) begin
				report_fault("result strobe with no operation outstanding");
			end else begin
				want = replies_due.pop_front();
				if (popped_value !== want.pop_val)
					report_fault($sformatf("popped_value exp %0d got %0d",
						want.pop_val, popped_value));
				if (popped_priority !== want.pop_pri)
					report_fault($sformatf("popped_priority exp %0d got %0d",
						want.pop_pri, popped_priority));
				if (done_res !== want.stored)
					report_fault($sformatf("done_res exp %0d got %0d",
						want.stored, done_res));
				if (count_after !== want.count)
					report_fault($sformatf("count_after exp %0d got %0d",
						want.count, count_after));
			end
		end
	end

	task automatic test_pop_empty();
		send_op(OP_POP, 8'hFF, 3'd7);
	endtask

	// Fill with every priority code (out-of-range ones too), then push once more
	task automatic test_fill_and_overflow();
		logic [PRI_W-1:0]       pris [16];
		logic [VALUE_WIDTH-1:0] vals [16];
		pris = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
			3'd4, 3'd3, 3'd2, 3'd1, 3'd7, 3'd0, 3'd3, 3'd2};
		vals = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04,
			8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C};
		for (int i = 0; i < 16; i++) begin
			send_op(OP_PUSH, vals[i], pris[i]);
		end
		// queue is full: this one must be dropped
		send_op(OP_PUSH, 8'h80, 3'd4);
	endtask

	// Pop the head several times: highest priority first, oldest first within it
	task automatic test_drain_order();
		for (int i = 0; i < 6; i++) begin
			send_op(OP_POP, 8'(i), 3'(i));
		end
	endtask

	// Segments biased toward push, pop or neither, so full and empty are both hit often
	task automatic test_random_traffic(input int n_items);
		int push_pct;
		bit gaps_on;
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 75;
				endcase
				gaps_on = ($urandom_range(0, 2) != 0) && (k < n_items - 200);
			end
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				idle_cycles($urandom_range(1, 13));
			end
			send_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
				VALUE_WIDTH'($urandom), PRI_W'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		start        <= 1'b0;
		operation    <= OP_PUSH;
		value        <= '0;
		priority_req <= '0;
		held_count   = 0;
		fault_count  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pop_empty();
		test_fill_and_overflow();
		test_drain_order();
		test_random_traffic(1200);

		// drain outstanding results, then allow for stray strobes
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
